>>> rtl/min_cost_max_flow_engine_assert.svh
// assertion macros for the min-cost max-flow engine
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef MIN_COST_MAX_FLOW_ENGINE_ASSERT_SVH
`define MIN_COST_MAX_FLOW_ENGINE_ASSERT_SVH

// condition in the same cycle implies consequence
`define MCMF_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define MCMF_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mcmf_pkg.sv
// shared types, widths and helpers for the min-cost max-flow engine
// no dependencies
package mcmf_pkg;

    localparam int VTX_W          = 7;
    localparam int CAP_W          = 16;
    localparam int COST_W         = 16;
    localparam int TOTAL_W        = 48;
    localparam int MAX_VERTICES_D = 64;
    localparam int MAX_EDGES_D    = 256;

    // one stored edge holds the forward arc and its reverse arc
    typedef struct packed {
        logic [VTX_W-1:0]         tail;
        logic [VTX_W-1:0]         head;
        logic signed [COST_W-1:0] cost;
        logic [CAP_W-1:0]         res_fwd;
        logic [CAP_W-1:0]         res_rev;
    } t_edge;

    typedef struct packed {
        logic [VTX_W-1:0]       from;
        logic [VTX_W-1:0]       to;
        logic signed [COST_W:0] cost;
        logic [CAP_W-1:0]       resid;
    } t_arc;

    function automatic t_arc arc_of(input t_edge e, input logic rev);
        t_arc a;
        if (rev) begin
            a.from  = e.head;
            a.to    = e.tail;
            a.cost  = -(COST_W+1)'(e.cost);
            a.resid = e.res_rev;
        end else begin
            a.from  = e.tail;
            a.to    = e.head;
            a.cost  = (COST_W+1)'(e.cost);
            a.resid = e.res_fwd;
        end
        return a;
    endfunction

endpackage

>>> rtl/min_cost_max_flow_engine.sv
// min-cost max-flow engine top level: edge loading, bellman-ford search, augmentation
// depends on mcmf_pkg, mcmf_ram and min_cost_max_flow_engine_assert.svh
//
// usage:
//  edges enter on the input channel (i_valid / o_ready), one transaction per cycle
//  while the block is loading; each edge is written to the edge ram as it is taken.
//  an edge with i_last_edge set starts the solve; o_ready stays low until the
//  result is written to the output register. edges beyond MAX_EDGES are dropped.
//  the vertex count register is written through i_cfg_we / i_cfg_wdata; the user
//  must write it only while idle, since the block itself does not enforce this.
//  solve: each bellman-ford pass reads one arc at a time (edge ram read, then
//  two distance ram reads, then compare and write back), n-1 passes per search;
//  the single edge ram read port and the registered distance ram reads set these steps.
//  the result leaves on the output channel (o_valid / i_ready) from an output
//  register; new edges are taken while a result waits, and a finished solve waits
//  for the output register to free up when the receiver stalls.
//  synchronous active-low reset: empty graph, vertex count 2, no result pending.
module min_cost_max_flow_engine
    import mcmf_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_D,
    parameter int MAX_EDGES    = MAX_EDGES_D
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [VTX_W-1:0]          i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [VTX_W-1:0]          i_tail_vertex,
    input  logic [VTX_W-1:0]          i_head_vertex,
    input  logic [CAP_W-1:0]          i_edge_capacity,
    input  logic signed [COST_W-1:0]  i_edge_cost,
    input  logic                      i_last_edge,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [TOTAL_W-1:0] o_total_cost,
    output logic                      o_cost_overflow
);

    `include "min_cost_max_flow_engine_assert.svh"

    localparam int DEPTH_V = MAX_VERTICES + 1;
    localparam int VIW     = $clog2(DEPTH_V);
    localparam int EW      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW      = $clog2(MAX_EDGES + 1);
    localparam int DW      = $clog2(MAX_VERTICES) + $clog2(2 * MAX_EDGES) + COST_W + 2;
    localparam int PW      = EW + 1;
    localparam int EDW     = $bits(t_edge);
    localparam int PRW     = CAP_W + COST_W + 1;

    localparam logic signed [TOTAL_W-1:0] COST_HI = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] COST_LO = {1'b1, {(TOTAL_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_ARC, S_EDGE, S_CMP,
        S_WPRED, S_WEDGE, S_WSTEP,
        S_APRED, S_AEDGE, S_AUPD, S_AACC, S_DONE
    } t_state;

    t_state                      r_state;
    logic [VTX_W-1:0]            r_cfg_n;
    logic [VTX_W-1:0]            r_n;
    logic [CW-1:0]               r_edge_count;
    logic [CW-1:0]               r_e;
    logic                        r_dir;
    logic [VTX_W-1:0]            r_pass;
    logic [DEPTH_V-1:0]          r_known;
    t_arc                        r_arc;
    logic [VTX_W-1:0]            r_v;
    logic [VTX_W-1:0]            r_steps;
    logic [CAP_W:0]              r_push;
    logic [PW-1:0]               r_pe;
    logic signed [PRW-1:0]       r_prod;
    logic signed [TOTAL_W-1:0]   r_acc;
    logic                        r_sat;
    logic                        r_out_valid;
    logic signed [TOTAL_W-1:0]   r_out_cost;
    logic                        r_out_ovf;

    // ram ports
    logic              edge_we;
    logic [EW-1:0]     edge_waddr;
    t_edge             edge_wdata;
    logic [EW-1:0]     edge_raddr;
    logic [EDW-1:0]    edge_rdata;
    t_edge             edge_rd;
    logic              dist_we;
    logic [VIW-1:0]    dist_waddr;
    logic [DW-1:0]     dist_wdata;
    logic [DW-1:0]     dist_a_rdata;
    logic [DW-1:0]     dist_b_rdata;
    logic              pred_we;
    logic [PW-1:0]     pred_rdata;

    t_arc                     arc_rd;
    t_arc                     arc_pe;
    logic                     accept;
    logic                     arc_ok;
    logic                     relax;
    logic signed [DW-1:0]     d_from;
    logic signed [DW-1:0]     d_to;
    logic signed [DW-1:0]     cand;
    logic signed [TOTAL_W:0]  acc_sum;
    logic [VTX_W-1:0]         n_eff;

    assign edge_rd = t_edge'(edge_rdata);
    assign arc_rd  = arc_of(edge_rd, r_dir);
    assign arc_pe  = arc_of(edge_rd, r_pe[0]);
    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_LOAD);

    assign n_eff = (32'(r_cfg_n) > MAX_VERTICES) ? VTX_W'(MAX_VERTICES) : r_cfg_n;

    assign d_from = $signed(dist_a_rdata);
    assign d_to   = $signed(dist_b_rdata);
    assign cand   = d_from + DW'(r_arc.cost);
    assign arc_ok = (r_arc.from != '0) && (r_arc.from <= r_n) &&
                    (r_arc.to != '0) && (r_arc.to <= r_n) &&
                    r_known[VIW'(r_arc.from)] && (r_arc.resid != '0);
    assign relax  = (r_state == S_CMP) && arc_ok &&
                    (!r_known[VIW'(r_arc.to)] || (cand < d_to));

    assign acc_sum = {r_acc[TOTAL_W-1], r_acc} + (TOTAL_W+1)'(r_prod);

    // edge ram: written on load and on augmentation
    always_comb begin
        edge_we    = 1'b0;
        edge_waddr = r_edge_count[EW-1:0];
        edge_wdata = '0;
        if (r_state == S_AUPD) begin
            edge_we    = 1'b1;
            edge_waddr = r_pe[PW-1:1];
            edge_wdata = edge_rd;
            if (r_pe[0]) begin
                edge_wdata.res_rev = edge_rd.res_rev - r_push[CAP_W-1:0];
                edge_wdata.res_fwd = edge_rd.res_fwd + r_push[CAP_W-1:0];
            end else begin
                edge_wdata.res_fwd = edge_rd.res_fwd - r_push[CAP_W-1:0];
                edge_wdata.res_rev = edge_rd.res_rev + r_push[CAP_W-1:0];
            end
        end else if (accept && (r_edge_count != CW'(MAX_EDGES))) begin
            edge_we            = 1'b1;
            edge_wdata.tail    = i_tail_vertex;
            edge_wdata.head    = i_head_vertex;
            edge_wdata.cost    = i_edge_cost;
            edge_wdata.res_fwd = i_edge_capacity;
            edge_wdata.res_rev = '0;
        end
    end

    assign edge_raddr = (r_state == S_ARC) ? r_e[EW-1:0] : pred_rdata[PW-1:1];

    // distance rams hold identical copies so both arc ends are read in the same cycle
    assign dist_we    = (r_state == S_INIT) || relax;
    assign dist_waddr = (r_state == S_INIT) ? VIW'(1) : VIW'(r_arc.to);
    assign dist_wdata = (r_state == S_INIT) ? '0 : cand;
    assign pred_we    = relax;

    mcmf_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (EDW'(edge_wdata)),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    mcmf_ram #(.WIDTH(DW), .DEPTH(DEPTH_V)) u_dist_a_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (VIW'(arc_rd.from)),
        .o_rdata (dist_a_rdata)
    );

    mcmf_ram #(.WIDTH(DW), .DEPTH(DEPTH_V)) u_dist_b_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (VIW'(arc_rd.to)),
        .o_rdata (dist_b_rdata)
    );

    mcmf_ram #(.WIDTH(PW), .DEPTH(DEPTH_V)) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (pred_we),
        .i_waddr (VIW'(r_arc.to)),
        .i_wdata ({r_e[EW-1:0], r_dir}),
        .i_raddr (VIW'(r_v)),
        .o_rdata (pred_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_cfg_n      <= VTX_W'(2);
            r_edge_count <= '0;
            r_out_valid  <= 1'b0;
            r_known      <= '0;
            r_acc        <= '0;
            r_sat        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_n <= i_cfg_wdata;
            end
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (r_edge_count != CW'(MAX_EDGES)) begin
                            r_edge_count <= r_edge_count + 1'b1;
                        end
                        if (i_last_edge) begin
                            r_acc <= '0;
                            r_sat <= 1'b0;
                            r_n   <= n_eff;
                            r_state <= (n_eff < VTX_W'(2)) ? S_DONE : S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    // only the source is known at the start of a search
                    r_known    <= DEPTH_V'(2);
                    r_pass     <= '0;
                    r_e        <= '0;
                    r_dir      <= 1'b0;
                    r_state    <= S_ARC;
                end
                S_ARC: begin
                    if (r_e == r_edge_count) begin
                        // end of one pass over all arcs
                        r_e   <= '0;
                        r_dir <= 1'b0;
                        r_pass <= r_pass + 1'b1;
                        if (r_pass + VTX_W'(2) >= r_n) begin
                            r_v     <= r_n;
                            r_steps <= '0;
                            r_push  <= '1;
                            r_state <= r_known[VIW'(r_n)] ? S_WPRED : S_DONE;
                        end
                    end else begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_arc   <= arc_rd;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (relax) begin
                        r_known[VIW'(r_arc.to)] <= 1'b1;
                    end
                    r_dir <= ~r_dir;
                    if (r_dir) begin
                        r_e <= r_e + 1'b1;
                    end
                    r_state <= S_ARC;
                end
                S_WPRED: begin
                    priority if (r_v == VTX_W'(1)) begin
                        r_v     <= r_n;
                        r_state <= S_APRED;
                    end else if (r_steps == r_n) begin
                        // chain caught in a negative cycle
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WEDGE;
                    end
                end
                S_WEDGE: begin
                    r_pe    <= pred_rdata;
                    r_state <= S_WSTEP;
                end
                S_WSTEP: begin
                    if ({1'b0, arc_pe.resid} < r_push) begin
                        r_push <= {1'b0, arc_pe.resid};
                    end
                    r_v     <= arc_pe.from;
                    r_steps <= r_steps + 1'b1;
                    r_state <= S_WPRED;
                end
                S_APRED: begin
                    r_state <= (r_v == VTX_W'(1)) ? S_INIT : S_AEDGE;
                end
                S_AEDGE: begin
                    r_pe    <= pred_rdata;
                    r_state <= S_AUPD;
                end
                S_AUPD: begin
                    r_prod  <= $signed({1'b0, r_push[CAP_W-1:0]}) * arc_pe.cost;
                    r_v     <= arc_pe.from;
                    r_state <= S_AACC;
                end
                S_AACC: begin
                    if (acc_sum[TOTAL_W] != acc_sum[TOTAL_W-1]) begin
                        r_acc <= acc_sum[TOTAL_W] ? COST_LO : COST_HI;
                        r_sat <= 1'b1;
                    end else begin
                        r_acc <= acc_sum[TOTAL_W-1:0];
                    end
                    r_state <= S_APRED;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_cost   <= r_acc;
                        r_out_ovf    <= r_sat;
                        r_edge_count <= '0;
                        r_state      <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_total_cost    = r_out_cost;
    assign o_cost_overflow = r_out_ovf;

    `MCMF_ASSERT_NEXT(a_last_stops_input, accept && i_last_edge, !o_ready,
        "input still taken after the last edge")
    `MCMF_ASSERT_SAME(a_push_nonzero, r_state == S_AUPD, r_push != '0,
        "augmenting with zero bottleneck")
    `MCMF_ASSERT_SAME(a_edge_count_bound, 1'b1, r_edge_count <= CW'(MAX_EDGES),
        "edge count beyond ram depth")

endmodule

>>> rtl/mcmf_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
